// File: rtl/core/kct_pkg.sv
// Shared types, codes and default sizes for the keyed credit table.
// No dependencies; used by kct_cell and keyed_credit_table_with_max.
`timescale 1ns / 1ps

package kct_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int CREDIT_BITS_DEF = 32;

    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int IO_W     = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_ADD    = 3'd3,
        OP_MAX    = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } ctl_state_t;

    typedef struct packed {
        logic valid;
        logic match_hit;
        logic free_hit;
        logic best_hit;
    } wave_flags_t;

    typedef struct packed {
        logic we;
        logic clr;
    } wr_ctl_t;

endpackage

// File: rtl/core/kct_cell.sv
// One slot of the credit table: holds a key and credit, and folds its
// match, free-slot and maximum results into the passing wave. Uses kct_pkg.
`timescale 1ns / 1ps

module kct_cell #(
    parameter int IDX         = 0,
    parameter int IDX_W       = 4,
    parameter int KEY_BITS    = kct_pkg::KEY_BITS_DEF,
    parameter int CREDIT_BITS = kct_pkg::CREDIT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CREDIT_BITS-1:0]  offset,
    input  logic [KEY_BITS-1:0]     cmd_key,
    input  kct_pkg::wr_ctl_t        wr_ctl,
    input  logic [IDX_W-1:0]        wr_idx,
    input  logic [KEY_BITS-1:0]     wr_key,
    input  logic [CREDIT_BITS-1:0]  wr_credit,
    input  kct_pkg::wave_flags_t    in_flags,
    input  logic [IDX_W-1:0]        in_match_idx,
    input  logic [CREDIT_BITS-1:0]  in_match_eff,
    input  logic [IDX_W-1:0]        in_free_idx,
    input  logic [CREDIT_BITS-1:0]  in_best_eff,
    input  logic [KEY_BITS-1:0]     in_best_key,
    output kct_pkg::wave_flags_t    out_flags,
    output logic [IDX_W-1:0]        out_match_idx,
    output logic [CREDIT_BITS-1:0]  out_match_eff,
    output logic [IDX_W-1:0]        out_free_idx,
    output logic [CREDIT_BITS-1:0]  out_best_eff,
    output logic [KEY_BITS-1:0]     out_best_key
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                   valid_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [CREDIT_BITS-1:0] credit_reg;

    kct_pkg::wave_flags_t   flags_reg, flags_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic [CREDIT_BITS-1:0] match_eff_reg, match_eff_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [CREDIT_BITS-1:0] best_eff_reg, best_eff_next;
    logic [KEY_BITS-1:0]    best_key_reg, best_key_next;

    logic [CREDIT_BITS-1:0] eff;
    logic                   hit;
    logic                   take_match;
    logic                   take_free;
    logic                   take_best;
    logic                   wr_here;

    assign eff     = offset + credit_reg;
    assign hit     = valid_reg && (key_reg == cmd_key);
    assign wr_here = wr_ctl.we && (wr_idx == MY_IDX);

    always_comb
    begin
        take_match = hit && !in_flags.match_hit;
        take_free  = !valid_reg && !in_flags.free_hit;
        take_best  = valid_reg &&
                     (!in_flags.best_hit || ($signed(eff) > $signed(in_best_eff)));

        flags_next.valid     = in_flags.valid;
        flags_next.match_hit = in_flags.match_hit || hit;
        flags_next.free_hit  = in_flags.free_hit || !valid_reg;
        flags_next.best_hit  = in_flags.best_hit || valid_reg;

        match_idx_next = take_match ? MY_IDX : in_match_idx;
        match_eff_next = take_match ? eff : in_match_eff;
        free_idx_next  = take_free ? MY_IDX : in_free_idx;
        best_eff_next  = take_best ? eff : in_best_eff;
        best_key_next  = take_best ? key_reg : in_best_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (wr_here)
            begin
                valid_reg <= !wr_ctl.clr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here && !wr_ctl.clr)
        begin
            key_reg    <= wr_key;
            credit_reg <= wr_credit;
        end
        match_idx_reg <= match_idx_next;
        match_eff_reg <= match_eff_next;
        free_idx_reg  <= free_idx_next;
        best_eff_reg  <= best_eff_next;
        best_key_reg  <= best_key_next;
    end

    assign out_flags     = flags_reg;
    assign out_match_idx = match_idx_reg;
    assign out_match_eff = match_eff_reg;
    assign out_free_idx  = free_idx_reg;
    assign out_best_eff  = best_eff_reg;
    assign out_best_key  = best_key_reg;

endmodule

// File: rtl/core/keyed_credit_table_with_max.sv
// Keyed credit table with add-to-all and maximum: a chain of kct_cell slots
// swept by one wave per item, then a single commit cycle. Uses kct_pkg.
// Timing: the item passes launch_reg, then each slot's wave register; done is
// registered from the commit cycle. One item at a time: the wave advances
// one cell per cycle along the slot chain; busy stays high meanwhile.
// Reset: all slots empty, offset zero; the receiver cannot stall results.
`timescale 1ns / 1ps

module keyed_credit_table_with_max #(
    parameter int ENTRIES     = kct_pkg::ENTRIES_DEF,
    parameter int KEY_BITS    = kct_pkg::KEY_BITS_DEF,
    parameter int CREDIT_BITS = kct_pkg::CREDIT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [kct_pkg::OPCODE_W-1:0]        opcode,
    input  logic [kct_pkg::IO_W-1:0]            client_key,
    input  logic signed [kct_pkg::IO_W-1:0]     amount,
    output logic                                busy,
    output logic                                done,
    output logic [kct_pkg::STATUS_W-1:0]        status,
    output logic signed [kct_pkg::IO_W-1:0]     credit_value,
    output logic [kct_pkg::IO_W-1:0]            found_key
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    kct_pkg::ctl_state_t      state_reg, state_next;
    logic                     launch_reg;
    kct_pkg::opcode_t         op_reg;
    logic [KEY_BITS-1:0]      cmd_key_reg;
    logic [CREDIT_BITS-1:0]   amt_reg;
    logic [CREDIT_BITS-1:0]   offset_reg, offset_next;

    logic                     done_reg;
    kct_pkg::status_t         status_reg, status_next;
    logic [kct_pkg::IO_W-1:0] value_reg, value_next;
    logic [kct_pkg::IO_W-1:0] fkey_reg, fkey_next;

    logic                     accept;
    logic                     commit;

    kct_pkg::wr_ctl_t         wr_ctl;
    logic [IDX_W-1:0]         wr_idx;
    logic [CREDIT_BITS-1:0]   wr_credit;

    kct_pkg::wave_flags_t     w_flags     [ENTRIES+1];
    logic [IDX_W-1:0]         w_match_idx [ENTRIES+1];
    logic [CREDIT_BITS-1:0]   w_match_eff [ENTRIES+1];
    logic [IDX_W-1:0]         w_free_idx  [ENTRIES+1];
    logic [CREDIT_BITS-1:0]   w_best_eff  [ENTRIES+1];
    logic [KEY_BITS-1:0]      w_best_key  [ENTRIES+1];
    logic [ENTRIES:0]         wave_vld;

    kct_pkg::wave_flags_t     tail;

    always_comb
    begin
        w_flags[0]           = '0;
        w_flags[0].valid     = launch_reg;
        w_match_idx[0]       = '0;
        w_match_eff[0]       = '0;
        w_free_idx[0]        = '0;
        w_best_eff[0]        = '0;
        w_best_key[0]        = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            kct_cell #(
                .IDX         (gi),
                .IDX_W       (IDX_W),
                .KEY_BITS    (KEY_BITS),
                .CREDIT_BITS (CREDIT_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .offset        (offset_reg),
                .cmd_key       (cmd_key_reg),
                .wr_ctl        (wr_ctl),
                .wr_idx        (wr_idx),
                .wr_key        (cmd_key_reg),
                .wr_credit     (wr_credit),
                .in_flags      (w_flags[gi]),
                .in_match_idx  (w_match_idx[gi]),
                .in_match_eff  (w_match_eff[gi]),
                .in_free_idx   (w_free_idx[gi]),
                .in_best_eff   (w_best_eff[gi]),
                .in_best_key   (w_best_key[gi]),
                .out_flags     (w_flags[gi+1]),
                .out_match_idx (w_match_idx[gi+1]),
                .out_match_eff (w_match_eff[gi+1]),
                .out_free_idx  (w_free_idx[gi+1]),
                .out_best_eff  (w_best_eff[gi+1]),
                .out_best_key  (w_best_key[gi+1])
            );
        end
        for (gi = 0; gi <= ENTRIES; gi++)
        begin : g_vld
            assign wave_vld[gi] = w_flags[gi].valid;
        end
    endgenerate

    assign tail = w_flags[ENTRIES];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kct_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = kct_pkg::S_SCAN;
                end
            end
            kct_pkg::S_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = kct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kct_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy   = 1'b1;
        commit = 1'b0;
        case (state_reg)
            kct_pkg::S_IDLE:
            begin
                busy = 1'b0;
            end
            kct_pkg::S_SCAN:
            begin
                commit = tail.valid;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign accept = start && !busy;

    // resolve the item at the tail of the chain
    always_comb
    begin
        status_next = kct_pkg::ST_OK;
        value_next  = '0;
        fkey_next   = '0;
        offset_next = offset_reg;
        wr_ctl      = '0;
        wr_idx      = w_match_idx[ENTRIES];
        wr_credit   = amt_reg - offset_reg;
        case (op_reg)
            kct_pkg::OP_INSERT:
            begin
                if (tail.match_hit)
                begin
                    wr_ctl.we = commit;
                end
                else if (tail.free_hit)
                begin
                    wr_ctl.we = commit;
                    wr_idx    = w_free_idx[ENTRIES];
                end
                else
                begin
                    status_next = kct_pkg::ST_FULL;
                end
            end
            kct_pkg::OP_REMOVE:
            begin
                if (tail.match_hit)
                begin
                    wr_ctl.we  = commit;
                    wr_ctl.clr = 1'b1;
                end
                else
                begin
                    status_next = kct_pkg::ST_MISS;
                end
            end
            kct_pkg::OP_LOOKUP:
            begin
                if (tail.match_hit)
                begin
                    value_next = kct_pkg::IO_W'(w_match_eff[ENTRIES]);
                end
                else
                begin
                    status_next = kct_pkg::ST_MISS;
                end
            end
            kct_pkg::OP_ADD:
            begin
                offset_next = offset_reg + amt_reg;
            end
            kct_pkg::OP_MAX:
            begin
                if (tail.best_hit)
                begin
                    value_next = kct_pkg::IO_W'(w_best_eff[ENTRIES]);
                    fkey_next  = kct_pkg::IO_W'(w_best_key[ENTRIES]);
                end
                else
                begin
                    status_next = kct_pkg::ST_MISS;
                end
            end
            default:
            begin
                status_next = kct_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= kct_pkg::S_IDLE;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
            offset_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept;
            done_reg   <= commit;
            if (commit)
            begin
                offset_reg <= offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= kct_pkg::opcode_t'(opcode);
            cmd_key_reg <= KEY_BITS'(client_key);
            amt_reg     <= CREDIT_BITS'(amount);
        end
        if (commit)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            fkey_reg   <= fkey_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign credit_value = value_reg;
    assign found_key    = fkey_reg;

    a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wave_vld))
        else $error("more than one item in the slot chain");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && launch_reg)
        else $error("item taken without launching a wave");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == kct_pkg::S_SCAN)
        else $error("wave reached the tail outside a scan");

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> done && !busy)
        else $error("result not strobed after commit");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == kct_pkg::ST_FULL) |-> (credit_value == '0 && found_key == '0))
        else $error("full status with non-zero payload");

endmodule
